FILE: rtl/iir_biquad_cascade_df2t_core_defines.svh
`ifndef IIR_BIQUAD_CASCADE_DF2T_CORE_DEFINES_SVH
`define IIR_BIQUAD_CASCADE_DF2T_CORE_DEFINES_SVH

// same-cycle implication check
`define IBC_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("ibc check failed");

// next-cycle implication check
`define IBC_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("ibc check failed");

`endif

FILE: rtl/ibc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibc_pkg;

   localparam int SECTIONS_DEFAULT       = 4;
   localparam int COEF_FRAC_BITS_DEFAULT = 14;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 18;
   localparam int SIG_W       = 40;
   localparam int PROD_W      = COEF_W + SIG_W;
   localparam int COEF_SLOTS  = 5;
   localparam int SLOT_W      = 3;
   localparam int SECTION_W   = 4;
   localparam int BIT_CNT_W   = $clog2(COEF_W);

   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_COEF   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_ACCUM,
      ST_DONE
   } state_type;

   // order of the products inside one section
   typedef enum logic [2:0] {
      STEP_B0,
      STEP_B1,
      STEP_A1,
      STEP_B2,
      STEP_A2
   } step_type;

   function automatic logic [SLOT_W-1:0] slot_of(input step_type step);
      logic [SLOT_W-1:0] slot;
      case (step)
         STEP_B0: slot = SLOT_B0;
         STEP_B1: slot = SLOT_B1;
         STEP_A1: slot = SLOT_A1;
         STEP_B2: slot = SLOT_B2;
         STEP_A2: slot = SLOT_A2;
         default: slot = SLOT_B0;
      endcase
      return slot;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/iir_biquad_cascade_df2t_core.sv
// a sample steps FETCH, LOAD, MUL, ACCUM per product, then DONE until its response loads
// each section runs five products through one bit-serial shift-add multiplier
// a new sample is not taken before the last is through; req_stall is high outside IDLE
// coefficient writes are taken one per cycle while the core is idle and give no response
// reset is synchronous; it clears control and the per-entry valid bits of both
// stores, so every coefficient and delay reads zero until written (no clearing pass)
`timescale 1ns / 1ps
`default_nettype none
`include "iir_biquad_cascade_df2t_core_defines.svh"

module iir_biquad_cascade_df2t_core
   import ibc_pkg::*;
#(
   parameter int SECTIONS       = SECTIONS_DEFAULT,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,

   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        req_mode,
   input  wire signed [SAMPLE_W-1:0]  req_sample_in,
   input  wire        [SECTION_W-1:0] req_coef_section,
   input  wire        [SLOT_W-1:0]    req_coef_slot,
   input  wire signed [COEF_W-1:0]    req_coef_value,

   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_clipped
);

   localparam int COEF_DEPTH  = COEF_SLOTS * SECTIONS;
   localparam int DELAY_DEPTH = 2 * SECTIONS;
   localparam int CA_W        = $clog2(COEF_DEPTH);
   localparam int DA_W        = $clog2(DELAY_DEPTH);
   localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int SUM_W       = PROD_W - COEF_FRAC_BITS + 2;
   localparam int RND_W       = SIG_W + 1;

   localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'(32767);
   localparam logic signed [RND_W-1:0] OUT_MIN = -RND_W'(32768);

   // saturate a wide sum to the signal range
   function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
      logic signed [SIG_W-1:0] r;
      if (&v[SUM_W-1:SIG_W-1] || ~|v[SUM_W-1:SIG_W-1]) begin
         r = v[SIG_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(SIG_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SIG_W-1){1'b1}}};
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   step_type  step_ff;

   logic [SEC_W-1:0]     sec_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;

   logic signed [SIG_W-1:0]  x_ff;
   logic signed [SIG_W-1:0]  y_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic        [PROD_W-1:0] mcand_ff;
   logic        [COEF_W-1:0] mplier_ff;

   logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
   logic        [COEF_DEPTH-1:0] coef_vld_ff;
   logic signed [COEF_W-1:0] coef_rd_ff;
   logic                     coef_rd_vld_ff;

   logic signed [SIG_W-1:0] delay_mem [DELAY_DEPTH];
   logic        [DELAY_DEPTH-1:0] delay_vld_ff;
   logic signed [SIG_W-1:0] delay_rd_ff;
   logic                    delay_rd_vld_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_out_ff;
   logic                       rsp_clipped_ff;

   logic req_take, start, coef_we, rsp_load, delay_we, mul_last;
   logic [CA_W-1:0] coef_wr_addr, coef_rd_addr;
   logic [DA_W-1:0] delay_rd_addr, delay_wr_addr;

   logic signed [PROD_W-1:0] acc_in;
   logic        [PROD_W-1:0] addend;
   logic signed [PROD_W-1:0] acc_shift;
   logic signed [SUM_W-1:0]  term;
   logic signed [SUM_W-1:0]  delay_ext;
   logic signed [SIG_W-1:0]  mul_src;
   logic signed [SIG_W-1:0]  delay_wr_data;
   logic signed [RND_W-1:0]  rnd;
   logic signed [RND_W-1:0]  trunc_y;
   logic signed [SAMPLE_W-1:0] out_sample;
   logic                       out_clip;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_mode == MODE_FILTER) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL: begin
            if (mul_last) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (step_ff == STEP_A2 && sec_ff == SEC_W'(SECTIONS - 1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      req_take  = req_valid && !req_stall;
      start     = req_take && req_mode == MODE_FILTER;
      coef_we   = req_take && req_mode == MODE_COEF
                  && ({1'b0, req_coef_section} < (SECTION_W + 1)'(SECTIONS))
                  && req_coef_slot <= SLOT_A2;
      delay_we  = (state_ff == ST_ACCUM) && (step_ff == STEP_A1 || step_ff == STEP_A2);
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      mul_last  = (bit_cnt_ff == BIT_CNT_W'(COEF_W - 1));
   end

   // addressing
   always_comb begin
      coef_wr_addr  = CA_W'(32'(req_coef_section) * COEF_SLOTS + 32'(req_coef_slot));
      coef_rd_addr  = CA_W'(32'(sec_ff) * COEF_SLOTS + 32'(slot_of(step_ff)));
      delay_rd_addr = DA_W'(32'(sec_ff) * 2 + ((step_ff == STEP_B0) ? 0 : 1));
      delay_wr_addr = DA_W'(32'(sec_ff) * 2 + ((step_ff == STEP_A1) ? 0 : 1));
   end

   // datapath arithmetic
   always_comb begin
      // sign bit of the coefficient has negative weight
      if (!mplier_ff[0]) begin
         addend = '0;
      end else if (mul_last) begin
         addend = ~mcand_ff;
      end else begin
         addend = mcand_ff;
      end
      acc_in = acc_ff + $signed(addend)
               + PROD_W'(mplier_ff[0] && mul_last);

      acc_shift = acc_ff >>> COEF_FRAC_BITS;
      term      = acc_shift[SUM_W-1:0];
      delay_ext = delay_rd_vld_ff
                  ? {{(SUM_W - SIG_W){delay_rd_ff[SIG_W-1]}}, delay_rd_ff} : '0;
      mul_src   = (step_ff inside {STEP_A1, STEP_A2}) ? y_ff : x_ff;
      delay_wr_data = sat_sig(sum_ff - term);

      // divide by 2^F rounding toward zero, then clamp to 16 bit
      rnd = {y_ff[SIG_W-1], y_ff}
            + (y_ff[SIG_W-1] ? RND_W'((1 << COEF_FRAC_BITS) - 1) : '0);
      trunc_y = rnd >>> COEF_FRAC_BITS;
      if (trunc_y > OUT_MAX) begin
         out_sample = 16'sh7fff;
         out_clip   = 1'b1;
      end else if (trunc_y < OUT_MIN) begin
         out_sample = 16'sh8000;
         out_clip   = 1'b1;
      end else begin
         out_sample = trunc_y[SAMPLE_W-1:0];
         out_clip   = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_B0;
         sec_ff       <= '0;
         bit_cnt_ff   <= '0;
         coef_vld_ff  <= '0;
         delay_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (coef_we) coef_vld_ff[coef_wr_addr] <= 1'b1;
         if (delay_we) delay_vld_ff[delay_wr_addr] <= 1'b1;
         if (start) begin
            step_ff <= STEP_B0;
            sec_ff  <= '0;
         end else if (state_ff == ST_ACCUM) begin
            case (step_ff)
               STEP_B0: step_ff <= STEP_B1;
               STEP_B1: step_ff <= STEP_A1;
               STEP_A1: step_ff <= STEP_B2;
               STEP_B2: step_ff <= STEP_A2;
               STEP_A2: begin
                  step_ff <= STEP_B0;
                  if (sec_ff != SEC_W'(SECTIONS - 1)) sec_ff <= sec_ff + 1'b1;
               end
               default: step_ff <= STEP_B0;
            endcase
         end
         if (state_ff == ST_LOAD) begin
            bit_cnt_ff <= '0;
         end else if (state_ff == ST_MUL) begin
            bit_cnt_ff <= bit_cnt_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[coef_wr_addr] <= req_coef_value;
      coef_rd_ff     <= coef_mem[coef_rd_addr];
      coef_rd_vld_ff <= coef_vld_ff[coef_rd_addr];
      if (delay_we) delay_mem[delay_wr_addr] <= delay_wr_data;
      delay_rd_ff     <= delay_mem[delay_rd_addr];
      delay_rd_vld_ff <= delay_vld_ff[delay_rd_addr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= {{(SIG_W - SAMPLE_W - COEF_FRAC_BITS){req_sample_in[SAMPLE_W-1]}},
                  req_sample_in, {COEF_FRAC_BITS{1'b0}}};
      end else if (state_ff == ST_ACCUM && step_ff == STEP_A2) begin
         x_ff <= y_ff;
      end

      if (state_ff == ST_LOAD) begin
         acc_ff    <= '0;
         mcand_ff  <= {{(PROD_W - SIG_W){mul_src[SIG_W-1]}}, mul_src};
         mplier_ff <= coef_rd_vld_ff ? coef_rd_ff : '0;
      end else if (state_ff == ST_MUL) begin
         acc_ff    <= acc_in;
         mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[COEF_W-1:1]};
      end

      if (state_ff == ST_ACCUM) begin
         case (step_ff)
            STEP_B0: y_ff   <= sat_sig(term + delay_ext);
            STEP_B1: sum_ff <= term + delay_ext;
            STEP_B2: sum_ff <= term;
            default: sum_ff <= sum_ff;
         endcase
      end

      if (rsp_load) begin
         rsp_sample_out_ff <= out_sample;
         rsp_clipped_ff    <= out_clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_clipped    = rsp_clipped_ff;

   `IBC_ASSERT_NEXT(a_start_section0, clock, reset, start,
      state_ff == ST_FETCH && sec_ff == '0 && step_ff == STEP_B0)
   `IBC_ASSERT_NEXT(a_mul_starts_clean, clock, reset, state_ff == ST_LOAD,
      state_ff == ST_MUL && bit_cnt_ff == '0)
   `IBC_ASSERT_NOW(a_clip_at_rail, clock, reset, rsp_valid_ff && rsp_clipped_ff,
      rsp_sample_out_ff == 16'sh7fff || rsp_sample_out_ff == 16'sh8000)

endmodule

`default_nettype wire
